### rtl/intcode_processor_core_top_assert.svh
// ----------------------------------------------------------------------------
// Intcode core assertion macros
// Shorthand for clocked, reset-qualified port checks.
// ----------------------------------------------------------------------------
`ifndef INTCODE_PROCESSOR_CORE_TOP_ASSERT_SVH
`define INTCODE_PROCESSOR_CORE_TOP_ASSERT_SVH

// Same-cycle implication check.
`define IPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("intcode core port check failed");

// Next-cycle implication check.
`define IPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("intcode core port check failed");

`endif

### rtl/ipc_pkg.sv
// ----------------------------------------------------------------------------
// Intcode core package
// Payload types, controller/datapath command and status, and shared codes.
// ----------------------------------------------------------------------------
package ipc_pkg;

  localparam int WORD_W            = 64;
  localparam int LOAD_ADDR_W       = 12;
  localparam int MEM_DEPTH_DEFAULT = 4096;
  localparam int OP_W              = 7;

  // Decimal decode: remainder of the word modulo 100000 holds all digits used.
  localparam int DEC_MOD = 100000;
  localparam int REM_W   = 17;
  localparam int MOD_T_W = 21;

  // Item kind.
  localparam logic ITEM_LOAD = 1'b0;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_OP   = 2'd1;
  localparam logic [1:0] ERR_BAD_MODE = 2'd2;
  localparam logic [1:0] ERR_RANGE    = 2'd3;

  // Instruction opcodes.
  localparam logic [OP_W-1:0] OP_ADD  = 7'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 7'd2;
  localparam logic [OP_W-1:0] OP_IN   = 7'd3;
  localparam logic [OP_W-1:0] OP_OUT  = 7'd4;
  localparam logic [OP_W-1:0] OP_JT   = 7'd5;
  localparam logic [OP_W-1:0] OP_JF   = 7'd6;
  localparam logic [OP_W-1:0] OP_LT   = 7'd7;
  localparam logic [OP_W-1:0] OP_EQ   = 7'd8;
  localparam logic [OP_W-1:0] OP_ARB  = 7'd9;
  localparam logic [OP_W-1:0] OP_HALT = 7'd99;

  // Parameter modes.
  localparam logic [3:0] MODE_POS = 4'd0;
  localparam logic [3:0] MODE_IMM = 4'd1;
  localparam logic [3:0] MODE_REL = 4'd2;

  // Datapath command codes.
  localparam logic [3:0] CMD_NONE    = 4'd0;
  localparam logic [3:0] CMD_CLEAR   = 4'd1;
  localparam logic [3:0] CMD_CAPTURE = 4'd2;
  localparam logic [3:0] CMD_LOAD    = 4'd3;
  localparam logic [3:0] CMD_FETCH   = 4'd4;
  localparam logic [3:0] CMD_WORD    = 4'd5;
  localparam logic [3:0] CMD_MOD     = 4'd6;
  localparam logic [3:0] CMD_DIGIT   = 4'd7;
  localparam logic [3:0] CMD_ARG_AT  = 4'd8;
  localparam logic [3:0] CMD_ARG_PTR = 4'd9;
  localparam logic [3:0] CMD_ARG_VAL = 4'd10;
  localparam logic [3:0] CMD_MUL     = 4'd11;
  localparam logic [3:0] CMD_EXEC    = 4'd12;
  localparam logic [3:0] CMD_HALT    = 4'd13;
  localparam logic [3:0] CMD_FAIL    = 4'd14;
  localparam logic [3:0] CMD_PUBLISH = 4'd15;

  typedef struct packed {
    logic                   opcode;
    logic [LOAD_ADDR_W-1:0] load_address;
    logic signed [WORD_W-1:0] word_value;
    logic                   input_offered;
  } item_t;

  typedef struct packed {
    logic                     out_valid;
    logic signed [WORD_W-1:0] out_value;
    logic                     input_taken;
    logic                     needs_input;
    logic                     halted_flag;
    logic [1:0]               error_code;
  } result_t;

  typedef struct packed {
    logic [3:0] code;
    logic [1:0] err;
    logic       adv_arg;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_load;
    logic halted;
    logic word_neg;
    logic mod_last;
    logic dig_last;
    logic op_ok;
    logic op_halt;
    logic op_mul;
    logic arg_last;
    logic at_bad;
    logic mode_bad;
    logic arg_imm;
    logic arg_tgt;
    logic addr_bad;
    logic mul_last;
    logic out_free;
  } dp_status_t;

  // Place value of the digit peeled at each decode step.
  function automatic logic [REM_W-1:0] dec_unit(input logic [1:0] sel);
    logic [REM_W-1:0] u;
    unique case (sel)
      2'd0:    u = REM_W'(10000);
      2'd1:    u = REM_W'(1000);
      default: u = REM_W'(100);
    endcase
    return u;
  endfunction

endpackage

### rtl/ipc_chan_if.sv
// ----------------------------------------------------------------------------
// Intcode core channel
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface ipc_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/ipc_ctrl.sv
// ----------------------------------------------------------------------------
// Intcode core controller
// Sequences clearing, loads and the fetch/decode/operand/execute steps.
// ----------------------------------------------------------------------------
module ipc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ipc_pkg::dp_status_t   status,
  output ipc_pkg::ctrl_cmd_t    cmd
);
  import ipc_pkg::*;

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_LOAD    = 4'd2;
  localparam logic [3:0] ST_FETCH   = 4'd3;
  localparam logic [3:0] ST_WORD    = 4'd4;
  localparam logic [3:0] ST_MOD     = 4'd5;
  localparam logic [3:0] ST_DIGIT   = 4'd6;
  localparam logic [3:0] ST_DECODE  = 4'd7;
  localparam logic [3:0] ST_ARG_AT  = 4'd8;
  localparam logic [3:0] ST_ARG_PTR = 4'd9;
  localparam logic [3:0] ST_ARG_VAL = 4'd10;
  localparam logic [3:0] ST_MUL     = 4'd11;
  localparam logic [3:0] ST_EXEC    = 4'd12;
  localparam logic [3:0] ST_DONE    = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] after_arg;

  // Where to go once the current operand is finished.
  always_comb begin
    if (!status.arg_last) begin
      after_arg = ST_ARG_AT;
    end else if (status.op_mul) begin
      after_arg = ST_MUL;
    end else begin
      after_arg = ST_EXEC;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_next  = state;
    cmd.code    = CMD_NONE;
    cmd.err     = ERR_NONE;
    cmd.adv_arg = 1'b0;
    in_ready    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.code = CMD_CLEAR;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.code   = CMD_CAPTURE;
          state_next = status.in_load ? ST_LOAD : ST_FETCH;
        end
      end
      ST_LOAD: begin
        cmd.code   = CMD_LOAD;
        state_next = ST_DONE;
      end
      ST_FETCH: begin
        if (status.halted) begin
          state_next = ST_DONE;
        end else begin
          cmd.code   = CMD_FETCH;
          state_next = ST_WORD;
        end
      end
      ST_WORD: begin
        if (status.word_neg) begin
          cmd.code   = CMD_FAIL;
          cmd.err    = ERR_BAD_OP;
          state_next = ST_DONE;
        end else begin
          cmd.code   = CMD_WORD;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.code = CMD_MOD;
        if (status.mod_last) begin
          state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        cmd.code = CMD_DIGIT;
        if (status.dig_last) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!status.op_ok) begin
          cmd.code   = CMD_FAIL;
          cmd.err    = ERR_BAD_OP;
          state_next = ST_DONE;
        end else if (status.op_halt) begin
          cmd.code   = CMD_HALT;
          state_next = ST_DONE;
        end else begin
          state_next = ST_ARG_AT;
        end
      end
      ST_ARG_AT: begin
        if (status.at_bad) begin
          cmd.code   = CMD_FAIL;
          cmd.err    = ERR_RANGE;
          state_next = ST_DONE;
        end else if (status.mode_bad) begin
          cmd.code   = CMD_FAIL;
          cmd.err    = ERR_BAD_MODE;
          state_next = ST_DONE;
        end else begin
          cmd.code   = CMD_ARG_AT;
          state_next = ST_ARG_PTR;
        end
      end
      ST_ARG_PTR: begin
        if (status.arg_imm) begin
          cmd.code    = CMD_ARG_PTR;
          cmd.adv_arg = 1'b1;
          state_next  = after_arg;
        end else if (status.addr_bad) begin
          cmd.code   = CMD_FAIL;
          cmd.err    = ERR_RANGE;
          state_next = ST_DONE;
        end else if (status.arg_tgt) begin
          cmd.code    = CMD_ARG_PTR;
          cmd.adv_arg = 1'b1;
          state_next  = after_arg;
        end else begin
          cmd.code   = CMD_ARG_PTR;
          state_next = ST_ARG_VAL;
        end
      end
      ST_ARG_VAL: begin
        cmd.code    = CMD_ARG_VAL;
        cmd.adv_arg = 1'b1;
        state_next  = after_arg;
      end
      ST_MUL: begin
        cmd.code = CMD_MUL;
        if (status.mul_last) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.code   = CMD_EXEC;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.code   = CMD_PUBLISH;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register; reset starts the memory clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/ipc_dpath.sv
// ----------------------------------------------------------------------------
// Intcode core datapath
// Program memory, machine registers, decimal decoder, multiplier and result.
// ----------------------------------------------------------------------------
module ipc_dpath #(
  parameter int MEM_DEPTH = ipc_pkg::MEM_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ipc_pkg::item_t       in_data,
  input  ipc_pkg::ctrl_cmd_t   cmd,
  output ipc_pkg::dp_status_t  status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output ipc_pkg::result_t     out_data
);
  import ipc_pkg::*;

  localparam int                AW      = $clog2(MEM_DEPTH);
  localparam logic [AW:0]       DEPTH_X = (AW+1)'(MEM_DEPTH);
  localparam logic [WORD_W-1:0] DEPTH_W = WORD_W'(MEM_DEPTH);

  // Program memory, single port with registered read.
  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] rdata;

  // Machine and control registers.
  logic [AW-1:0]     clr;
  logic [AW-1:0]     pc;
  logic [WORD_W-1:0] rb;
  logic              halted;
  logic              out_full;

  // Captured item.
  logic [LOAD_ADDR_W-1:0] it_la;
  logic [WORD_W-1:0]      it_val;
  logic                   it_offered;

  // Decoder registers.
  logic [WORD_W-1:0] ws;
  logic [3:0]        nib;
  logic [REM_W-1:0]  rem;
  logic [1:0]        dsel;
  logic [3:0]        m1;
  logic [3:0]        m2;
  logic [3:0]        m3;
  logic [OP_W-1:0]   op;

  // Operand and multiplier registers.
  logic [1:0]        k;
  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;
  logic [AW-1:0]     dst;
  logic [1:0]        mstep;
  logic [WORD_W-1:0] prod_r;
  logic [WORD_W-1:0] acc;

  // Working result.
  logic [1:0]        r_err;
  logic [WORD_W-1:0] r_outv;
  logic              r_valid;
  logic              r_taken;
  logic              r_needs;

  // Combinational helpers.
  logic [WORD_W-1:0]  la_w;
  logic               la_ok;
  logic [1:0]         n_read;
  logic               has_tgt;
  logic               op_ok;
  logic               op_halt;
  logic [1:0]         n_total;
  logic               arg_tgt;
  logic [3:0]         mode_cur;
  logic [AW:0]        at_x;
  logic [WORD_W-1:0]  ind_addr;
  logic [MOD_T_W-1:0] mod_t;
  logic [3:0]         mod_q;
  logic [REM_W-1:0]   mod_rem;
  logic [REM_W-1:0]   unit;
  logic [3:0]         dig_d;
  logic [REM_W-1:0]   dig_rem;
  logic [31:0]        mul_x;
  logic [31:0]        mul_y;
  logic [WORD_W-1:0]  prod;
  logic               jump_take;
  logic               jump_bad;
  logic               exec_we;
  logic [WORD_W-1:0]  exec_wdata;

  function automatic logic [AW-1:0] pc_step(input logic [AW-1:0] p, input logic [2:0] s);
    logic [AW:0] n;
    n = {1'b0, p} + (AW+1)'(s);
    if (n >= DEPTH_X) begin
      n = n - DEPTH_X;
    end
    return n[AW-1:0];
  endfunction

  // Load address check.
  assign la_w  = WORD_W'(it_la);
  assign la_ok = la_w < DEPTH_W;

  // Opcode classes: operand reads and whether a store target follows.
  always_comb begin
    n_read  = 2'd0;
    has_tgt = 1'b0;
    op_ok   = 1'b1;
    op_halt = 1'b0;
    unique case (op)
      OP_ADD, OP_MUL, OP_LT, OP_EQ: begin
        n_read  = 2'd2;
        has_tgt = 1'b1;
      end
      OP_IN: begin
        has_tgt = 1'b1;
      end
      OP_OUT, OP_ARB: begin
        n_read = 2'd1;
      end
      OP_JT, OP_JF: begin
        n_read = 2'd2;
      end
      OP_HALT: begin
        op_halt = 1'b1;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // Current operand: slot address, mode and indirect address.
  assign n_total  = n_read + 2'(has_tgt);
  assign arg_tgt  = has_tgt && (k == n_total);
  assign mode_cur = (k == 2'd1) ? m1 : ((k == 2'd2) ? m2 : m3);
  assign at_x     = {1'b0, pc} + (AW+1)'(k);
  assign ind_addr = ((mode_cur == MODE_REL) ? rb : '0) + rdata;

  // One nibble of the modulo-100000 reduction.
  always_comb begin
    mod_t = {rem, 4'b0000} + MOD_T_W'(ws[WORD_W-1 -: 4]);
    mod_q = 4'd0;
    for (int j = 1; j < 16; j++) begin
      if (mod_t >= MOD_T_W'(j * DEC_MOD)) begin
        mod_q = 4'(j);
      end
    end
    mod_rem = REM_W'(mod_t - MOD_T_W'(mod_q) * MOD_T_W'(DEC_MOD));
  end

  // One decimal digit peeled off the remainder.
  always_comb begin
    unit  = dec_unit(dsel);
    dig_d = 4'd0;
    for (int j = 1; j < 10; j++) begin
      if (rem >= REM_W'(j) * unit) begin
        dig_d = 4'(j);
      end
    end
    dig_rem = rem - REM_W'(dig_d) * unit;
  end

  // Shared 32x32 multiplier, one partial product per step.
  always_comb begin
    unique case (mstep)
      2'd0: begin
        mul_x = a[31:0];
        mul_y = b[31:0];
      end
      2'd1: begin
        mul_x = a[31:0];
        mul_y = b[63:32];
      end
      default: begin
        mul_x = a[63:32];
        mul_y = b[31:0];
      end
    endcase
  end
  assign prod = mul_x * mul_y;

  // Execute stage decisions.
  assign jump_take = (op == OP_JT) == (a != '0);
  assign jump_bad  = b >= DEPTH_W;

  always_comb begin
    exec_we    = 1'b0;
    exec_wdata = '0;
    unique case (op)
      OP_ADD: begin
        exec_we    = 1'b1;
        exec_wdata = a + b;
      end
      OP_MUL: begin
        exec_we    = 1'b1;
        exec_wdata = acc;
      end
      OP_LT: begin
        exec_we    = 1'b1;
        exec_wdata = WORD_W'($signed(a) < $signed(b));
      end
      OP_EQ: begin
        exec_we    = 1'b1;
        exec_wdata = WORD_W'(a == b);
      end
      OP_IN: begin
        exec_we    = it_offered;
        exec_wdata = it_val;
      end
      default: begin
        exec_we = 1'b0;
      end
    endcase
  end

  // Memory port selection.
  always_comb begin
    mem_addr  = pc;
    mem_we    = 1'b0;
    mem_wdata = '0;
    unique case (cmd.code)
      CMD_CLEAR: begin
        mem_addr = clr;
        mem_we   = 1'b1;
      end
      CMD_LOAD: begin
        mem_addr  = la_w[AW-1:0];
        mem_we    = la_ok;
        mem_wdata = it_val;
      end
      CMD_ARG_AT: begin
        mem_addr = at_x[AW-1:0];
      end
      CMD_ARG_PTR: begin
        mem_addr = ind_addr[AW-1:0];
      end
      CMD_EXEC: begin
        mem_addr  = dst;
        mem_we    = exec_we;
        mem_wdata = exec_wdata;
      end
      default: begin
        mem_addr = pc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  // Status back to the controller.
  always_comb begin
    status.clear_last = clr == AW'(MEM_DEPTH - 1);
    status.in_load    = in_data.opcode == ITEM_LOAD;
    status.halted     = halted;
    status.word_neg   = rdata[WORD_W-1];
    status.mod_last   = nib == 4'd0;
    status.dig_last   = dsel == 2'd2;
    status.op_ok      = op_ok;
    status.op_halt    = op_halt;
    status.op_mul     = op == OP_MUL;
    status.arg_last   = k == n_total;
    status.at_bad     = at_x >= DEPTH_X;
    status.mode_bad   = arg_tgt ? !(mode_cur == MODE_POS || mode_cur == MODE_REL)
                                : (mode_cur > MODE_REL);
    status.arg_imm    = !arg_tgt && (mode_cur == MODE_IMM);
    status.arg_tgt    = arg_tgt;
    status.addr_bad   = ind_addr >= DEPTH_W;
    status.mul_last   = mstep == 2'd3;
    status.out_free   = !out_full || out_ready;
  end

  // Machine state and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr      <= '0;
      pc       <= '0;
      rb       <= '0;
      halted   <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (cmd.code == CMD_CLEAR) begin
        clr <= clr + AW'(1);
      end
      if (cmd.code == CMD_HALT) begin
        halted <= 1'b1;
      end
      if (cmd.code == CMD_PUBLISH) begin
        out_full <= 1'b1;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
      if (cmd.code == CMD_EXEC) begin
        unique case (op)
          OP_ADD, OP_MUL, OP_LT, OP_EQ: begin
            pc <= pc_step(pc, 3'd4);
          end
          OP_IN: begin
            if (it_offered) begin
              pc <= pc_step(pc, 3'd2);
            end
          end
          OP_OUT: begin
            pc <= pc_step(pc, 3'd2);
          end
          OP_ARB: begin
            pc <= pc_step(pc, 3'd2);
            rb <= rb + a;
          end
          OP_JT, OP_JF: begin
            if (!jump_take) begin
              pc <= pc_step(pc, 3'd3);
            end else if (!jump_bad) begin
              pc <= b[AW-1:0];
            end
          end
          default: begin
            pc <= pc;
          end
        endcase
      end
    end
  end

  // Item capture, decoder, operands and working result.
  always_ff @(posedge clk) begin
    unique case (cmd.code)
      CMD_CAPTURE: begin
        it_la      <= in_data.load_address;
        it_val     <= in_data.word_value;
        it_offered <= in_data.input_offered;
        k          <= 2'd1;
        mstep      <= 2'd0;
        r_err      <= ERR_NONE;
        r_outv     <= '0;
        r_valid    <= 1'b0;
        r_taken    <= 1'b0;
        r_needs    <= 1'b0;
      end
      CMD_LOAD: begin
        if (!la_ok) begin
          r_err <= ERR_RANGE;
        end
      end
      CMD_WORD: begin
        ws   <= rdata;
        nib  <= 4'd15;
        rem  <= '0;
        dsel <= 2'd0;
      end
      CMD_MOD: begin
        rem <= mod_rem;
        ws  <= ws << 4;
        nib <= nib - 4'd1;
      end
      CMD_DIGIT: begin
        rem  <= dig_rem;
        dsel <= dsel + 2'd1;
        unique case (dsel)
          2'd0:    m3 <= dig_d;
          2'd1:    m2 <= dig_d;
          default: begin
            m1 <= dig_d;
            op <= OP_W'(dig_rem);
          end
        endcase
      end
      CMD_ARG_PTR: begin
        if (status.arg_imm) begin
          if (k == 2'd1) begin
            a <= rdata;
          end else begin
            b <= rdata;
          end
        end else if (arg_tgt) begin
          dst <= ind_addr[AW-1:0];
        end
        if (cmd.adv_arg) begin
          k <= k + 2'd1;
        end
      end
      CMD_ARG_VAL: begin
        if (k == 2'd1) begin
          a <= rdata;
        end else begin
          b <= rdata;
        end
        k <= k + 2'd1;
      end
      CMD_MUL: begin
        prod_r <= prod;
        mstep  <= mstep + 2'd1;
        unique case (mstep)
          2'd0:    acc <= acc;
          2'd1:    acc <= prod_r;
          default: acc <= acc + {prod_r[31:0], 32'b0};
        endcase
      end
      CMD_EXEC: begin
        unique case (op)
          OP_IN: begin
            r_taken <= it_offered;
            r_needs <= !it_offered;
          end
          OP_OUT: begin
            r_valid <= 1'b1;
            r_outv  <= a;
          end
          OP_JT, OP_JF: begin
            if (jump_take && jump_bad) begin
              r_err <= ERR_RANGE;
            end
          end
          default: begin
            r_valid <= 1'b0;
          end
        endcase
      end
      CMD_FAIL: begin
        r_err <= cmd.err;
      end
      CMD_PUBLISH: begin
        out_data.out_valid   <= r_valid;
        out_data.out_value   <= r_outv;
        out_data.input_taken <= r_taken;
        out_data.needs_input <= r_needs;
        out_data.halted_flag <= halted;
        out_data.error_code  <= r_err;
      end
      default: begin
        k <= k;
      end
    endcase
  end

  assign out_valid = out_full;

endmodule

### rtl/intcode_processor_core_top.sv
// ----------------------------------------------------------------------------
// Intcode processor core
// Load and single-step execution of decimal-encoded programs in local memory.
// ----------------------------------------------------------------------------
// After reset the block clears its MEM_DEPTH-word program memory, one word
// per cycle, and accepts no item until the clearing is done. A load item
// writes its word and then publishes its result. An execute item reduces
// the instruction word modulo 100000 four bits at a time, then peels off the
// mode digits; each operand is read through the single memory port, and a
// multiply adds partial-product steps on the shared 32x32 multiplier. A step
// after halt skips the fetch, and a negative instruction word fails before
// the decode. A finished result sits in an output register until it is
// taken; the next item is accepted once the result has been moved there, so
// a stalled result channel adds its stall cycles.
module intcode_processor_core_top #(
  parameter int MEM_DEPTH = ipc_pkg::MEM_DEPTH_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  ipc_chan_if.sink    items,
  ipc_chan_if.source  results
);
  import ipc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  ipc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Memory and machine state.
  ipc_dpath #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (items.data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .out_data  (results.data)
  );

endmodule

### rtl/ipc_checker.sv
// ----------------------------------------------------------------------------
// Intcode core port checker
// Checks result-channel behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "intcode_processor_core_top_assert.svh"

module ipc_checker (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input ipc_pkg::result_t out_data
);
  import ipc_pkg::*;

  logic seen_halt;

  // Remember that a halted result has been transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_halt <= 1'b0;
    end else if (out_valid && out_ready && out_data.halted_flag) begin
      seen_halt <= 1'b1;
    end
  end

  `IPC_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `IPC_ASSERT_IMPL(a_err_quiet, clk, rst, out_valid && out_data.error_code != ERR_NONE, !out_data.out_valid && !out_data.input_taken && !out_data.needs_input)
  `IPC_ASSERT_IMPL(a_out_zero, clk, rst, out_valid && !out_data.out_valid, out_data.out_value == '0)
  `IPC_ASSERT_IMPL(a_halt_sticky, clk, rst, out_valid && seen_halt, out_data.halted_flag)

endmodule

bind intcode_processor_core_top ipc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.data)
);

### sim/intcode_processor_core_top_tb.sv
// ----------------------------------------------------------------------------
// Intcode processor core testbench
// Loads short programs and steps them one instruction at a time, predicting
// every result in a scoreboard with its own memory, counter and relative base.
// ----------------------------------------------------------------------------
module intcode_processor_core_top_tb;
  import ipc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = MEM_DEPTH_DEFAULT;

  // Scoreboard: predicts each result from the accepted items.
  class core_scoreboard;
    logic [WORD_W-1:0] mem [0:DEPTH-1];
    int unsigned       pc;
    logic [WORD_W-1:0] rel_base;
    bit                halted;
    result_t           expected_q [$];
    int                mismatches;

    function new();
      foreach (mem[i]) mem[i] = '0;
      pc = 0;
      rel_base = '0;
      halted = 0;
      mismatches = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endfunction

    // Resolves a position or relative operand into a memory address.
    function logic [1:0] target(int unsigned at, int mode, output int unsigned addr);
      logic [WORD_W-1:0] a;
      addr = 0;
      if (at >= DEPTH) return ERR_RANGE;
      if (mode == MODE_POS) a = mem[at];
      else if (mode == MODE_REL) a = rel_base + mem[at];
      else return ERR_BAD_MODE;
      if (a >= DEPTH) return ERR_RANGE;
      addr = 32'(a);
      return ERR_NONE;
    endfunction

    function logic [1:0] operand(int unsigned at, int mode, output logic [WORD_W-1:0] v);
      int unsigned addr;
      logic [1:0]  err;
      v = '0;
      if (mode == MODE_IMM) begin
        if (at >= DEPTH) return ERR_RANGE;
        v = mem[at];
        return ERR_NONE;
      end
      err = target(at, mode, addr);
      if (err == ERR_NONE) v = mem[addr];
      return err;
    endfunction

    // Works out the result of one accepted item and queues it.
    function void note_item(item_t it);
      result_t           r;
      logic [WORD_W-1:0] w, a, b, s;
      logic [OP_W-1:0]   op;
      int                m1, m2, m3;
      int unsigned       dst, nxt;
      bit                moved;
      r = '0;
      a = '0;
      b = '0;
      dst = 0;
      nxt = 0;
      moved = 0;
      if (it.opcode == ITEM_LOAD) begin
        if (it.load_address < DEPTH) mem[it.load_address] = it.word_value;
        else r.error_code = ERR_RANGE;
      end else if (!halted) begin
        w = mem[pc];
        if (w[WORD_W-1]) begin
          r.error_code = ERR_BAD_OP;
        end else begin
          op = OP_W'(w % 100);
          m1 = int'((w / 100) % 10);
          m2 = int'((w / 1000) % 10);
          m3 = int'((w / 10000) % 10);
          case (op)
            OP_ADD, OP_MUL, OP_LT, OP_EQ: begin
              r.error_code = operand(pc + 1, m1, a);
              if (r.error_code == ERR_NONE) r.error_code = operand(pc + 2, m2, b);
              if (r.error_code == ERR_NONE) r.error_code = target(pc + 3, m3, dst);
              if (r.error_code == ERR_NONE) begin
                if (op == OP_ADD) s = a + b;
                else if (op == OP_MUL) s = a * b;
                else if (op == OP_LT) s = ($signed(a) < $signed(b)) ? 1 : 0;
                else s = (a == b) ? 1 : 0;
                mem[dst] = s;
                nxt = pc + 4;
                moved = 1;
              end
            end
            OP_IN: begin
              r.error_code = target(pc + 1, m1, dst);
              if (r.error_code == ERR_NONE) begin
                if (it.input_offered) begin
                  mem[dst] = it.word_value;
                  r.input_taken = 1;
                  nxt = pc + 2;
                  moved = 1;
                end else begin
                  r.needs_input = 1;
                end
              end
            end
            OP_OUT: begin
              r.error_code = operand(pc + 1, m1, a);
              if (r.error_code == ERR_NONE) begin
                r.out_valid = 1;
                r.out_value = a;
                nxt = pc + 2;
                moved = 1;
              end
            end
            OP_JT, OP_JF: begin
              r.error_code = operand(pc + 1, m1, a);
              if (r.error_code == ERR_NONE) r.error_code = operand(pc + 2, m2, b);
              if (r.error_code == ERR_NONE) begin
                if ((op == OP_JT) == (a != 0)) begin
                  if (b >= DEPTH) r.error_code = ERR_RANGE;
                  else begin
                    nxt = 32'(b);
                    moved = 1;
                  end
                end else begin
                  nxt = pc + 3;
                  moved = 1;
                end
              end
            end
            OP_ARB: begin
              r.error_code = operand(pc + 1, m1, a);
              if (r.error_code == ERR_NONE) begin
                rel_base = rel_base + a;
                nxt = pc + 2;
                moved = 1;
              end
            end
            OP_HALT: halted = 1;
            default: r.error_code = ERR_BAD_OP;
          endcase
        end
        // A counter that steps to or past the end wraps around by DEPTH.
        if (moved) pc = (nxt >= DEPTH) ? nxt - DEPTH : nxt;
      end
      r.halted_flag = halted;
      expected_q.insert(expected_q.size(), r);
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(result_t got);
      result_t e;
      if (expected_q.size() == 0) begin
        report("result with no expectation waiting");
        return;
      end
      e = expected_q.pop_front();
      if (got.out_valid !== e.out_valid)
        report($sformatf("out_valid %0b, expected %0b", got.out_valid, e.out_valid));
      if (got.out_value !== e.out_value)
        report($sformatf("out_value %0d, expected %0d", got.out_value, e.out_value));
      if (got.input_taken !== e.input_taken)
        report($sformatf("input_taken %0b, expected %0b", got.input_taken, e.input_taken));
      if (got.needs_input !== e.needs_input)
        report($sformatf("needs_input %0b, expected %0b", got.needs_input, e.needs_input));
      if (got.halted_flag !== e.halted_flag)
        report($sformatf("halted_flag %0b, expected %0b", got.halted_flag, e.halted_flag));
      if (got.error_code !== e.error_code)
        report($sformatf("error_code %0d, expected %0d", got.error_code, e.error_code));
    endfunction
  endclass

  logic clk;
  logic rst;

  ipc_chan_if #(.payload_t(item_t))   items_if ();
  ipc_chan_if #(.payload_t(result_t)) results_if ();

  intcode_processor_core_top #(.MEM_DEPTH(DEPTH)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if.sink),
    .results (results_if.source)
  );

  core_scoreboard sb = new();
  int  sent_items;
  bit  send_calm;
  bit  recv_calm;

  // Clock.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard limit on the run.
  initial begin
    #30ms;
    $display("intcode_processor_core_top_tb failed");
    $finish;
  end

  // Drives one item and waits for its transfer.
  task automatic send(item_t it);
    int gap;
    if (sent_items % 150 == 0) send_calm = ($urandom_range(0, 3) == 0);
    gap = send_calm ? 0 : $urandom_range(0, 18);
    @(negedge clk);
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.data  <= it;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    sb.note_item(it);
    sent_items++;
  endtask

  task automatic load_word(int unsigned addr, logic [WORD_W-1:0] v);
    item_t it;
    it = '0;
    it.opcode = ITEM_LOAD;
    it.load_address = LOAD_ADDR_W'(addr);
    it.word_value = v;
    it.input_offered = $urandom_range(0, 1);
    send(it);
  endtask

  task automatic execute(logic [WORD_W-1:0] v, bit offered);
    item_t it;
    it = '0;
    it.opcode = ~ITEM_LOAD;
    it.load_address = LOAD_ADDR_W'($urandom_range(0, DEPTH - 1));
    it.word_value = v;
    it.input_offered = offered;
    send(it);
  endtask

  function automatic logic [WORD_W-1:0] any_word();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return {1'b0, {(WORD_W-1){1'b1}}};
    if (sel == 1) return {1'b1, {(WORD_W-1){1'b0}}};
    if (sel == 2) return '1;
    if (sel < 6) return WORD_W'($signed($urandom_range(0, 200)) - 100);
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WORD_W-1:0] jump_dest();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return $urandom_range(0, DEPTH - 1);
    if (sel < 9) return $urandom_range(DEPTH - 16, DEPTH - 1);
    return {$urandom, $urandom};
  endfunction

  // One random instruction, sometimes malformed: its data, its words at the counter, one step.
  task automatic run_instruction();
    int                op, nargs, i, sel;
    int                modes [3];
    logic [WORD_W-1:0] prm [3];
    logic [WORD_W-1:0] w, addr;
    int unsigned       at;
    bit                is_dst, is_jump;
    at = sb.pc;
    sel = $urandom_range(0, 99);
    if (sel < 2) op = -1;
    else if (sel < 5) op = $urandom_range(0, 1) ? 0 : $urandom_range(10, 98);
    else op = $urandom_range(OP_ADD, OP_ARB);
    case (op)
      OP_ADD, OP_MUL, OP_LT, OP_EQ: nargs = 3;
      OP_JT, OP_JF:                 nargs = 2;
      OP_IN, OP_OUT, OP_ARB:        nargs = 1;
      default:                      nargs = 0;
    endcase
    for (i = 0; i < 3; i++) begin
      is_dst = (i == 2 && nargs == 3) || (i == 0 && op == OP_IN);
      is_jump = (i == 1 && (op == OP_JT || op == OP_JF));
      sel = $urandom_range(0, 99);
      if (sel < 5) modes[i] = $urandom_range(3, 9);
      else if (is_dst) modes[i] = (sel < 12) ? MODE_IMM : ((sel % 2) ? MODE_POS : MODE_REL);
      else modes[i] = $urandom_range(MODE_POS, MODE_REL);
      if (modes[i] == MODE_IMM) begin
        if (is_jump) prm[i] = jump_dest();
        else if (op == OP_ARB) prm[i] = WORD_W'($signed($urandom_range(0, 100)) - 50);
        else prm[i] = any_word();
      end else begin
        addr = ($urandom_range(0, 24) == 0) ? {$urandom, $urandom}
                                            : $urandom_range(3000, 3300);
        prm[i] = (modes[i] == MODE_REL) ? addr - sb.rel_base : addr;
        if (i < nargs && !is_dst && addr < DEPTH && $urandom_range(0, 1))
          load_word(32'(addr), is_jump ? jump_dest() : any_word());
      end
    end
    if (op < 0) begin
      w = {1'b1, 31'($urandom), $urandom};
    end else begin
      w = op + modes[0] * 100 + modes[1] * 1000 + modes[2] * 10000;
      if ($urandom_range(0, 3) == 0) w = w + $urandom_range(0, 9000) * 100000;
    end
    load_word(at, w);
    for (i = 0; i < nargs; i++)
      if (at + 1 + i < DEPTH) load_word(at + 1 + i, prm[i]);
    execute(any_word(), (op == OP_IN) ? ($urandom_range(0, 3) != 0) : $urandom_range(0, 1));
  endtask

  // Result side: random stalls, then check each transfer.
  initial begin
    int gap;
    int taken_count;
    taken_count = 0;
    results_if.ready = 1'b0;
    forever begin
      if (taken_count % 150 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      gap = recv_calm ? 0 : $urandom_range(0, 18);
      @(negedge clk);
      if (gap > 0) begin
        results_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      results_if.ready <= 1'b1;
      @(posedge clk);
      while (!(results_if.valid && !rst)) @(posedge clk);
      sb.check_result(results_if.data);
      taken_count++;
    end
  end

  // Stimulus.
  initial begin
    sent_items = 0;
    send_calm = 0;
    recv_calm = 0;
    items_if.valid = 1'b0;
    items_if.data = '0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Extreme words, then add, missing and offered input, output, negative and bad opcodes, bad mode.
    load_word(DEPTH - 1, {1'b0, {(WORD_W-1){1'b1}}});
    load_word(10, {1'b1, {(WORD_W-1){1'b0}}});
    load_word(0, OP_ADD);
    load_word(1, 10);
    load_word(2, DEPTH - 1);
    load_word(3, 11);
    execute('1, 1'b0);
    load_word(4, OP_IN);
    load_word(5, 12);
    execute('1, 1'b0);
    execute('1, 1'b1);
    load_word(6, OP_OUT + MODE_IMM * 100);
    load_word(7, {1'b1, {(WORD_W-1){1'b0}}});
    execute('0, 1'b1);
    load_word(8, -5);
    execute('0, 1'b0);
    load_word(8, 42);
    execute('0, 1'b0);
    load_word(8, OP_ADD + 30000);
    load_word(9, 12);
    load_word(10, 4);
    execute('0, 1'b0);

    while (sent_items < 1740) run_instruction();

    // Halt, then steps and a load after the halt.
    load_word(sb.pc, OP_HALT);
    execute('0, 1'b0);
    execute(any_word(), 1'b1);
    load_word(20, any_word());
    execute('0, 1'b0);

    @(negedge clk);
    items_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("intcode_processor_core_top_tb passed");
    end else begin
      $display("intcode_processor_core_top_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/ipc_pkg.sv
rtl/ipc_chan_if.sv
rtl/ipc_ctrl.sv
rtl/ipc_dpath.sv
rtl/intcode_processor_core_top.sv
rtl/ipc_checker.sv
sim/intcode_processor_core_top_tb.sv
